// File: rtl/core/svm_pkg.sv
package svm_pkg;

	localparam logic [15:0] UNITY15 = 16'h8000;
	localparam logic [31:0] UNITY31 = 32'h8000_0000;

	typedef enum logic [2:0] {
		ACT_WRITE  = 3'd0,
		ACT_START  = 3'd1,
		ACT_VOLUME = 3'd2,
		ACT_FADE   = 3'd3,
		ACT_STOP   = 3'd4,
		ACT_MIX    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		REG_CLIP_LENGTH = 2'd0,
		REG_LOOP_ENABLE = 2'd1,
		REG_PHASE_STEP  = 2'd2,
		REG_MASTER_GAIN = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VOL,
		ST_SDIV,
		ST_SLOPE,
		ST_RD_A,
		ST_RD_B,
		ST_I_LOAD,
		ST_I_RUN,
		ST_G_LOAD,
		ST_G_RUN,
		ST_P_LOAD,
		ST_P_RUN,
		ST_ACC,
		ST_UPD,
		ST_MDIV,
		ST_FIN,
		ST_OUT
	} svm_state_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [11:0]        frame_index;
		logic signed [15:0] sample_left;
		logic signed [15:0] sample_right;
		logic [15:0]        target_left;
		logic [15:0]        target_right;
		logic [19:0]        ramp_frames;
		logic signed [15:0] mix_left;
		logic signed [15:0] mix_right;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic               voice_active;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [19:0] wdata;
	} cfg_item_t;

	typedef struct packed {
		logic [31:0]        gain;
		logic signed [31:0] slope;
		logic [19:0]        count;
	} ramp_t;

endpackage

// File: rtl/core/svm_if.sv
interface svm_in_if;
	logic              valid;
	logic              ready;
	svm_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svm_out_if;
	logic               valid;
	logic               ready;
	svm_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svm_cfg_if;
	logic               valid;
	logic               ready;
	svm_pkg::cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/sample_voice_mixer_unit.sv
// One stereo playback voice mixed into a stream of frames. Clip writes, start
// and stop are handled in the idle state. A volume change or fade works per
// channel: a channel that snaps is set directly, and a channel that ramps gets
// its slope from a 32-step bit-serial divider. A mix frame of a playing voice
// takes two clip reads, then per channel three bit-serial shift-add multiplies
// (interpolation, gain times master, sample times gain), then 32 divider steps
// for the phase wrap. A mix frame of an idle voice passes the mix through.
// The output word sits in its own register, so the next item is taken while
// it waits. CLIP_FRAMES must be a power of two.
module sample_voice_mixer_unit #(
	parameter int CLIP_FRAMES     = 4096,
	parameter int PHASE_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	svm_in_if.sink    item,
	svm_out_if.source result,
	svm_cfg_if.sink   cfg
);
	import svm_pkg::*;

	localparam int AW   = $clog2(CLIP_FRAMES);
	localparam int FB   = PHASE_FRAC_BITS;
	localparam int LW   = $clog2(CLIP_FRAMES + 1);
	localparam int CW   = (LW > 13) ? LW : 13;
	localparam int SWW  = (20 - FB > 0) ? 20 - FB : 1;
	localparam int WW   = ((AW > SWW) ? AW : SWW) + 1;
	localparam int MW   = (FB > 16) ? FB : 16;
	localparam int CNTW = $clog2(((MW > 32) ? MW : 32) + 1);

	svm_state_t state_q, state_d;

	// configuration
	logic [12:0] clip_len_q;
	logic        loop_q;
	logic [19:0] step_q;
	logic [15:0] master_q;

	// voice state
	logic              ch_q;
	logic              running_q, fade_q;
	logic [AW-1:0]     phase_whole_q;
	logic [FB-1:0]     phase_frac_q;
	logic [31:0]       gain_l_q, gain_r_q;
	logic [15:0]       goal_l_q, goal_r_q;
	logic signed [31:0] slope_l_q, slope_r_q;
	logic [19:0]       cnt_l_q, cnt_r_q;
	logic              res_v_q;

	// work registers
	in_item_t           item_q;
	logic [31:0]        clip_mem [CLIP_FRAMES];
	logic [31:0]        rd_q, a_q;
	logic signed [63:0] mcand_q, acc_q;
	logic [MW-1:0]      mplier_q;
	logic [CNTW-1:0]    cnt_q;
	logic signed [15:0] s_q, out_l_q, out_r_q;
	logic [31:0]        dvd_q;
	logic [19:0]        rem_q, dvs_q;
	logic               neg_q, fade_end_q;
	logic [WW-1:0]      whole_q;
	out_item_t          res_q;

	// control outputs
	logic          mem_we, mem_re, out_load;
	logic [AW-1:0] rd_addr;

	// combinational helpers
	logic [CW-1:0]      len_c, valid_c;
	logic [CW-1:0]      idx_inc_c;
	logic [AW-1:0]      nxt_c;
	logic [15:0]        mg_c;
	logic [FB+19:0]     step_ext_c;
	logic [FB:0]        frac_sum_c;
	logic [WW-1:0]      whole_c;
	logic signed [15:0] a_ch_c, b_ch_c, mix_ch_c;
	logic signed [16:0] dba_c;
	logic signed [17:0] s_c;
	logic signed [63:0] addend_c, rnd_c;
	logic signed [18:0] sum_c;
	logic signed [15:0] sat_c;
	logic [15:0]        vt_c;
	logic [31:0]        gain_ch_c;
	logic signed [33:0] diff_c;
	logic [31:0]        mag_c;
	logic               imm_c, last_c;
	logic [20:0]        r2_c;
	logic               ge_c;
	logic signed [31:0] slope_c;
	ramp_t              rl_c, rr_c;

	function automatic logic [15:0] sat15(input logic [15:0] v);
		return (v > UNITY15) ? UNITY15 : v;
	endfunction

	function automatic ramp_t ramp_next(input logic [31:0] gain, input logic signed [31:0] slope,
		input logic [19:0] count, input logic [15:0] goal);
		ramp_t r;
		logic signed [33:0] g;
		r.gain  = gain;
		r.slope = slope;
		r.count = count;
		g = $signed({2'b00, gain}) + 34'(slope);
		if (count != 20'd0) begin
			if (g < 0) begin
				r.gain = 32'd0;
			end else if (g > 34'sh0_8000_0000) begin
				r.gain = UNITY31;
			end else begin
				r.gain = g[31:0];
			end
			r.count = count - 20'd1;
			if (r.count == 20'd0) begin
				r.gain  = {goal, 16'h0000};
				r.slope = 32'sd0;
			end
		end
		return r;
	endfunction

	always_comb begin
		if (CW'(clip_len_q) < CW'(2)) begin
			len_c = CW'(2);
		end else if (CW'(clip_len_q) > CW'(CLIP_FRAMES)) begin
			len_c = CW'(CLIP_FRAMES);
		end else begin
			len_c = CW'(clip_len_q);
		end
		valid_c    = loop_q ? len_c : len_c - CW'(1);
		idx_inc_c  = CW'(phase_whole_q) + CW'(1);
		nxt_c      = (idx_inc_c >= len_c) ? '0 : idx_inc_c[AW-1:0];
		mg_c       = sat15(master_q);
		step_ext_c = (FB + 20)'(step_q);
		frac_sum_c = {1'b0, phase_frac_q} + {1'b0, step_ext_c[FB-1:0]};
		whole_c    = WW'(phase_whole_q) + WW'(step_ext_c >> FB) + WW'(frac_sum_c[FB]);

		a_ch_c   = ch_q ? $signed(a_q[31:16]) : $signed(a_q[15:0]);
		b_ch_c   = ch_q ? $signed(rd_q[31:16]) : $signed(rd_q[15:0]);
		mix_ch_c = ch_q ? item_q.mix_right : item_q.mix_left;
		dba_c    = 17'(b_ch_c) - 17'(a_ch_c);
		s_c      = 18'(a_ch_c) + 18'(acc_q >>> FB);

		// last multiplier step of the signed pass carries negative weight
		last_c = (cnt_q == CNTW'(1));
		if (!mplier_q[0]) begin
			addend_c = 64'sd0;
		end else if (state_q == ST_P_RUN && last_c) begin
			addend_c = -mcand_q;
		end else begin
			addend_c = mcand_q;
		end
		rnd_c = acc_q + 64'sh0000_2000_0000_0000;
		sum_c = 19'(mix_ch_c) + 19'($signed(rnd_c[63:46]));
		if (sum_c > 19'sd32767) begin
			sat_c = 16'sh7FFF;
		end else if (sum_c < -19'sd32768) begin
			sat_c = 16'sh8000;
		end else begin
			sat_c = sum_c[15:0];
		end

		if (item_q.action == ACT_FADE) begin
			vt_c = 16'd0;
		end else begin
			vt_c = sat15(ch_q ? item_q.target_right : item_q.target_left);
		end
		gain_ch_c = ch_q ? gain_r_q : gain_l_q;
		diff_c    = $signed({2'b00, vt_c, 16'h0000}) - $signed({2'b00, gain_ch_c});
		mag_c     = diff_c[33] ? 32'(-diff_c) : diff_c[31:0];
		imm_c     = (item_q.ramp_frames == 20'd0) || (diff_c == 34'sd0);

		r2_c = {rem_q, dvd_q[31]};
		ge_c = (r2_c >= {1'b0, dvs_q});

		if (neg_q) begin
			slope_c = -$signed(dvd_q);
		end else if (dvd_q[31]) begin
			slope_c = 32'sh7FFF_FFFF;
		end else begin
			slope_c = $signed(dvd_q);
		end

		rl_c = ramp_next(gain_l_q, slope_l_q, cnt_l_q, goal_l_q);
		rr_c = ramp_next(gain_r_q, slope_r_q, cnt_r_q, goal_r_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					case (item.data.action)
						ACT_VOLUME, ACT_FADE: state_d = ST_VOL;
						ACT_MIX:              state_d = running_q ? ST_RD_A : ST_OUT;
						default:              state_d = ST_IDLE;
					endcase
				end
			end
			ST_VOL: begin
				if (!imm_c) begin
					state_d = ST_SDIV;
				end else begin
					state_d = ch_q ? ST_IDLE : ST_VOL;
				end
			end
			ST_SDIV:   state_d = last_c ? ST_SLOPE : ST_SDIV;
			ST_SLOPE:  state_d = ch_q ? ST_IDLE : ST_VOL;
			ST_RD_A:   state_d = ST_RD_B;
			ST_RD_B:   state_d = ST_I_LOAD;
			ST_I_LOAD: state_d = ST_I_RUN;
			ST_I_RUN:  state_d = last_c ? ST_G_LOAD : ST_I_RUN;
			ST_G_LOAD: state_d = ST_G_RUN;
			ST_G_RUN:  state_d = last_c ? ST_P_LOAD : ST_G_RUN;
			ST_P_LOAD: state_d = ST_P_RUN;
			ST_P_RUN:  state_d = last_c ? ST_ACC : ST_P_RUN;
			ST_ACC:    state_d = ch_q ? ST_UPD : ST_I_LOAD;
			ST_UPD:    state_d = ST_MDIV;
			ST_MDIV:   state_d = last_c ? ST_FIN : ST_MDIV;
			ST_FIN:    state_d = ST_OUT;
			ST_OUT:    state_d = out_load ? ST_IDLE : ST_OUT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item.ready = (state_q == ST_IDLE);
		mem_we     = (state_q == ST_IDLE) && item.valid && (item.data.action == ACT_WRITE);
		mem_re     = (state_q == ST_RD_A) || (state_q == ST_RD_B);
		rd_addr    = (state_q == ST_RD_B) ? nxt_c : phase_whole_q;
		out_load   = (state_q == ST_OUT) && (!res_v_q || result.ready);
	end

	assign cfg.ready    = 1'b1;
	assign result.valid = res_v_q;
	assign result.data  = res_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			clip_mem[AW'(item.data.frame_index)] <= {item.data.sample_right, item.data.sample_left};
		end
		if (mem_re) begin
			rd_q <= clip_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_len_q <= 13'd2;
			loop_q     <= 1'b0;
			step_q     <= 20'h10000;
			master_q   <= UNITY15;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				REG_CLIP_LENGTH: clip_len_q <= cfg.data.wdata[12:0];
				REG_LOOP_ENABLE: loop_q     <= cfg.data.wdata[0];
				REG_PHASE_STEP:  step_q     <= cfg.data.wdata;
				REG_MASTER_GAIN: master_q   <= cfg.data.wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ch_q          <= 1'b0;
			running_q     <= 1'b0;
			fade_q        <= 1'b0;
			phase_whole_q <= '0;
			phase_frac_q  <= '0;
			gain_l_q      <= UNITY31;
			gain_r_q      <= UNITY31;
			goal_l_q      <= UNITY15;
			goal_r_q      <= UNITY15;
			slope_l_q     <= 32'sd0;
			slope_r_q     <= 32'sd0;
			cnt_l_q       <= 20'd0;
			cnt_r_q       <= 20'd0;
			res_v_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					ch_q <= 1'b0;
					if (item.valid) begin
						case (item.data.action)
							ACT_START: begin
								phase_whole_q <= '0;
								phase_frac_q  <= '0;
								gain_l_q      <= {sat15(item.data.target_left), 16'h0000};
								gain_r_q      <= {sat15(item.data.target_right), 16'h0000};
								goal_l_q      <= sat15(item.data.target_left);
								goal_r_q      <= sat15(item.data.target_right);
								slope_l_q     <= 32'sd0;
								slope_r_q     <= 32'sd0;
								cnt_l_q       <= 20'd0;
								cnt_r_q       <= 20'd0;
								running_q     <= 1'b1;
								fade_q        <= 1'b0;
							end
							ACT_FADE: fade_q    <= 1'b1;
							ACT_STOP: running_q <= 1'b0;
							default: ;
						endcase
					end
				end
				ST_VOL: begin
					if (ch_q) begin
						goal_r_q <= vt_c;
					end else begin
						goal_l_q <= vt_c;
					end
					if (imm_c) begin
						ch_q <= 1'b1;
						if (ch_q) begin
							gain_r_q  <= {vt_c, 16'h0000};
							slope_r_q <= 32'sd0;
							cnt_r_q   <= 20'd0;
						end else begin
							gain_l_q  <= {vt_c, 16'h0000};
							slope_l_q <= 32'sd0;
							cnt_l_q   <= 20'd0;
						end
					end
				end
				ST_SLOPE: begin
					ch_q <= 1'b1;
					if (ch_q) begin
						slope_r_q <= slope_c;
						cnt_r_q   <= item_q.ramp_frames;
					end else begin
						slope_l_q <= slope_c;
						cnt_l_q   <= item_q.ramp_frames;
					end
				end
				ST_ACC: ch_q <= 1'b1;
				ST_UPD: begin
					phase_frac_q <= frac_sum_c[FB-1:0];
					gain_l_q     <= rl_c.gain;
					slope_l_q    <= rl_c.slope;
					cnt_l_q      <= rl_c.count;
					gain_r_q     <= rr_c.gain;
					slope_r_q    <= rr_c.slope;
					cnt_r_q      <= rr_c.count;
				end
				ST_FIN: begin
					// fade end wins over the clip end
					if (fade_end_q) begin
						running_q     <= 1'b0;
						phase_whole_q <= rem_q[AW-1:0];
					end else if (32'(whole_q) >= 32'(valid_c)) begin
						if (loop_q) begin
							phase_whole_q <= rem_q[AW-1:0];
						end else begin
							running_q     <= 1'b0;
							phase_whole_q <= '0;
							phase_frac_q  <= '0;
						end
					end else begin
						phase_whole_q <= whole_q[AW-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					item_q  <= item.data;
					out_l_q <= item.data.mix_left;
					out_r_q <= item.data.mix_right;
				end
			end
			ST_VOL: begin
				dvd_q <= mag_c;
				rem_q <= 20'd0;
				dvs_q <= item_q.ramp_frames;
				cnt_q <= CNTW'(32);
				neg_q <= diff_c[33];
			end
			ST_SDIV, ST_MDIV: begin
				rem_q <= ge_c ? 20'(r2_c - {1'b0, dvs_q}) : r2_c[19:0];
				dvd_q <= {dvd_q[30:0], ge_c};
				cnt_q <= cnt_q - CNTW'(1);
			end
			ST_RD_B: a_q <= rd_q;
			ST_I_LOAD: begin
				mcand_q  <= 64'(dba_c);
				mplier_q <= MW'(phase_frac_q);
				acc_q    <= 64'sd0;
				cnt_q    <= CNTW'(FB);
			end
			ST_G_LOAD: begin
				s_q      <= s_c[15:0];
				mcand_q  <= $signed({32'd0, gain_ch_c});
				mplier_q <= MW'(mg_c);
				acc_q    <= 64'sd0;
				cnt_q    <= CNTW'(16);
			end
			ST_P_LOAD: begin
				mcand_q  <= acc_q;
				mplier_q <= MW'($unsigned(s_q));
				acc_q    <= 64'sd0;
				cnt_q    <= CNTW'(16);
			end
			ST_I_RUN, ST_G_RUN, ST_P_RUN: begin
				acc_q    <= acc_q + addend_c;
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q - CNTW'(1);
			end
			ST_ACC: begin
				if (ch_q) begin
					out_r_q <= sat_c;
				end else begin
					out_l_q <= sat_c;
				end
			end
			ST_UPD: begin
				whole_q    <= whole_c;
				fade_end_q <= fade_q && (rl_c.count == 20'd0) && (rr_c.count == 20'd0);
				dvd_q      <= 32'(whole_c);
				rem_q      <= 20'd0;
				dvs_q      <= 20'(valid_c);
				cnt_q      <= CNTW'(32);
			end
			ST_OUT: begin
				if (out_load) begin
					res_q.out_left     <= out_l_q;
					res_q.out_right    <= out_r_q;
					res_q.voice_active <= running_q;
				end
			end
			default: ;
		endcase
	end

	a_stop_src: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_FIN))
		else $error("voice stopped outside stop action or frame finish");

	a_slope_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_l_q == 20'd0 && cnt_r_q == 20'd0) |-> (slope_l_q == 32'sd0 && slope_r_q == 32'sd0))
		else $error("slope left over with no ramp running");

	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_l_q <= UNITY31) && (gain_r_q <= UNITY31))
		else $error("gain above unity");

	a_word_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> ($past(state_q) == ST_OUT))
		else $error("output word raised outside output state");

endmodule
